### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the derivative FLL derotator.
// Depends on nothing; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a boolean expression at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// Checks that the antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Checks that the antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hdl/dfd_pkg.sv
// Package of the derivative FLL derotator: widths, register indexes, FSM
// and command types, and the sine table. Depends on nothing.
`timescale 1ns / 1ps

package dfd_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int PHASE_BITS     = 32;
   localparam int TRIG_ADDR_BITS = 10;

   localparam int FREQ_BITS  = 32;
   localparam int GAIN_BITS  = 16;
   localparam int SHIFT_BITS = 6;
   localparam int PEND_W     = 2 * SAMPLE_BITS + 4;
   localparam int GPROD_W    = GAIN_BITS + PEND_W;
   localparam int TRIG_W     = 16;
   localparam int TRIG_FRAC  = 15;
   localparam int TRIG_ONE   = 32767;
   localparam int ROT_W      = SAMPLE_BITS + TRIG_W + 1;
   localparam int DIFF_W     = SAMPLE_BITS + 1;
   localparam int DPROD_W    = SAMPLE_BITS + DIFF_W;
   localparam int QLEN       = 1 << (TRIG_ADDR_BITS - 2);
   localparam int QIDX_W     = TRIG_ADDR_BITS - 1;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0]  CSR_LOOP_GAIN    = 1'b0;
   localparam logic [CSR_IDX_W-1:0]  CSR_GAIN_SHIFT   = 1'b1;
   localparam logic [SHIFT_BITS-1:0] GAIN_SHIFT_RESET = SHIFT_BITS'(32);

   localparam logic signed [ROT_W-1:0] SAT_HI = ROT_W'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [ROT_W-1:0] SAT_LO = -SAT_HI - ROT_W'(1);
   localparam logic signed [ROT_W-1:0] ROT_HALF = ROT_W'(1 << (TRIG_FRAC - 1));

   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint Q30_ONE     = 64'sd1 << 30;
   localparam longint HORNER_DIV [5] = '{110, 72, 42, 20, 6};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRIG,
      ST_MUL,
      ST_SUM,
      ST_DISC
   } dfd_state_type;

   // One-cycle strobes from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic trig;
      logic mul;
      logic sum;
      logic disc;
   } dfd_cmd_type;

   typedef logic [TRIG_FRAC-1:0] qsine_type [QLEN+1];

   // Quarter-wave sine, amplitude TRIG_ONE, from a truncated Taylor series
   // in Q30 evaluated with Horner's scheme. Runs at elaboration only.
   function automatic qsine_type build_qsine();
      qsine_type tab;
      longint x, x2, t, s, v;
      for (int j = 0; j <= QLEN; j++) begin
         x  = (HALF_PI_Q30 * longint'(j) + longint'(QLEN / 2)) / QLEN;
         x2 = (x * x + (64'sd1 <<< 29)) >>> 30;
         t  = Q30_ONE;
         for (int i = 0; i < 5; i++) begin
            t = Q30_ONE - ((x2 * t) >>> 30) / HORNER_DIV[i];
         end
         s = (x * t) >>> 30;
         v = (s * TRIG_ONE + (64'sd1 <<< 29)) >>> 30;
         if (v > TRIG_ONE) begin
            v = TRIG_ONE;
         end
         if (v < 0) begin
            v = 0;
         end
         tab[j] = v[TRIG_FRAC-1:0];
      end
      return tab;
   endfunction

   localparam qsine_type QSINE = build_qsine();

   // Full-wave sine from the quarter table by symmetry.
   function automatic logic signed [TRIG_W-1:0] sine_at(input logic [TRIG_ADDR_BITS-1:0] k);
      logic [1:0]               q;
      logic [QIDX_W-1:0]        j;
      logic [QIDX_W-1:0]        idx;
      logic signed [TRIG_W-1:0] v;
      q   = k[TRIG_ADDR_BITS-1 -: 2];
      j   = {1'b0, k[TRIG_ADDR_BITS-3:0]};
      idx = q[0] ? (QIDX_W'(QLEN) - j) : j;
      v   = TRIG_W'(QSINE[idx]);
      return q[1] ? -v : v;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [ROT_W-1:0] v);
      priority if (v > SAT_HI) begin
         return SAMPLE_BITS'(SAT_HI);
      end else if (v < SAT_LO) begin
         return SAMPLE_BITS'(SAT_LO);
      end else begin
         return v[SAMPLE_BITS-1:0];
      end
   endfunction

endpackage

### hdl/dfd_req_if.sv
// Input channel of the derivative FLL derotator: one complex sample a word.
// Depends on dfd_pkg.
`timescale 1ns / 1ps

interface dfd_req_if;
   import dfd_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] in_re;
   logic signed [SAMPLE_BITS-1:0] in_im;

   modport source (output valid, output in_re, output in_im, input ready);
   modport sink   (input valid, input in_re, input in_im, output ready);
endinterface

### hdl/dfd_rsp_if.sv
// Result channel of the derivative FLL derotator: derotated sample and
// frequency estimate a word. Depends on dfd_pkg.
`timescale 1ns / 1ps

interface dfd_rsp_if;
   import dfd_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_re;
   logic signed [SAMPLE_BITS-1:0] out_im;
   logic signed [FREQ_BITS-1:0]   freq_estimate;

   modport source (output valid, output out_re, output out_im, output freq_estimate,
                   input ready);
   modport sink   (input valid, input out_re, input out_im, input freq_estimate,
                   output ready);
endinterface

### hdl/dfd_ctrl.sv
// Controller of the derivative FLL derotator: sequences the four datapath
// steps and owns both handshakes. Depends on dfd_pkg.
`timescale 1ns / 1ps

module dfd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dfd_pkg::dfd_cmd_type cmd
);
   import dfd_pkg::*;

   dfd_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   // The output register can take a word when empty or emptied this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_TRIG;
            end
         end
         ST_TRIG: begin
            cmd.trig = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_DISC;
         end
         ST_DISC: begin
            if (out_free) begin
               cmd.disc  = 1'b1;
               req_ready = 1'b1;
               state_in  = req_valid ? ST_TRIG : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      cmd.load = req_valid && req_ready;
   end

   always_comb begin
      if (cmd.disc) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hdl/dfd_dpath.sv
// Datapath of the derivative FLL derotator: configuration registers, NCO,
// complex rotation, cross-product discriminator and loop filter.
// Depends on dfd_pkg.
`timescale 1ns / 1ps

module dfd_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  dfd_pkg::dfd_cmd_type                  cmd,
   input  logic                                  csr_wr_en,
   input  logic [dfd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [dfd_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic signed [dfd_pkg::SAMPLE_BITS-1:0] in_re,
   input  logic signed [dfd_pkg::SAMPLE_BITS-1:0] in_im,
   output logic signed [dfd_pkg::SAMPLE_BITS-1:0] out_re,
   output logic signed [dfd_pkg::SAMPLE_BITS-1:0] out_im,
   output logic signed [dfd_pkg::FREQ_BITS-1:0]   freq_estimate
);
   import dfd_pkg::*;

   // Configuration.
   logic signed [GAIN_BITS-1:0] loop_gain_ff;
   logic [SHIFT_BITS-1:0]       gain_shift_ff;

   // Loop state.
   logic [PHASE_BITS-1:0]         phase_ff;
   logic signed [FREQ_BITS-1:0]   freq_ff;
   logic signed [PEND_W-1:0]      pend_ff;
   logic signed [SAMPLE_BITS-1:0] p0_re_ff, p0_im_ff, p1_re_ff, p1_im_ff;

   // Per-sample work registers.
   logic signed [SAMPLE_BITS-1:0]        xr_ff, xi_ff;
   logic signed [TRIG_W-1:0]             sin_ff, cos_ff;
   logic signed [GPROD_W-1:0]            gprod_ff;
   logic signed [SAMPLE_BITS+TRIG_W-1:0] xr_c_ff, xi_s_ff, xi_c_ff, xr_s_ff;
   logic signed [SAMPLE_BITS-1:0]        rr_ff, ri_ff;
   logic signed [SAMPLE_BITS-1:0]        out_re_ff, out_im_ff;
   logic signed [FREQ_BITS-1:0]          freq_out_ff;

   logic [TRIG_ADDR_BITS-1:0]   trig_addr;
   logic signed [GPROD_W-1:0]   gprod_in;
   logic signed [GPROD_W-1:0]   gprod_shifted;
   logic signed [FREQ_BITS-1:0] freq_in;
   logic signed [ROT_W-1:0]     rot_re_sum, rot_im_sum;
   logic signed [DIFF_W-1:0]    diff_im, diff_re;
   logic signed [DPROD_W-1:0]   dprod_a, dprod_b;
   logic signed [PEND_W-1:0]    pend_in;

   assign trig_addr     = phase_ff[PHASE_BITS-1 -: TRIG_ADDR_BITS];
   assign gprod_in      = loop_gain_ff * pend_ff;
   assign gprod_shifted = gprod_ff >>> gain_shift_ff;
   assign freq_in       = freq_ff + gprod_shifted[FREQ_BITS-1:0];

   assign rot_re_sum = ROT_W'(xr_c_ff) + ROT_W'(xi_s_ff) + ROT_HALF;
   assign rot_im_sum = ROT_W'(xi_c_ff) - ROT_W'(xr_s_ff) + ROT_HALF;

   assign diff_im = DIFF_W'(ri_ff) - DIFF_W'(p0_im_ff);
   assign diff_re = DIFF_W'(rr_ff) - DIFF_W'(p0_re_ff);
   assign dprod_a = p1_re_ff * diff_im;
   assign dprod_b = p1_im_ff * diff_re;
   assign pend_in = PEND_W'(dprod_a) - PEND_W'(dprod_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_gain_ff  <= '0;
         gain_shift_ff <= GAIN_SHIFT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LOOP_GAIN:  loop_gain_ff  <= csr_wdata[GAIN_BITS-1:0];
            CSR_GAIN_SHIFT: gain_shift_ff <= csr_wdata[SHIFT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         freq_ff  <= '0;
         pend_ff  <= '0;
         p0_re_ff <= '0;
         p0_im_ff <= '0;
         p1_re_ff <= '0;
         p1_im_ff <= '0;
      end else begin
         // The error from the previous sample is filtered first.
         if (cmd.mul) begin
            freq_ff <= freq_in;
         end
         if (cmd.sum) begin
            phase_ff <= phase_ff + freq_ff[PHASE_BITS-1:0];
         end
         if (cmd.disc) begin
            pend_ff  <= pend_in;
            p0_re_ff <= p1_re_ff;
            p0_im_ff <= p1_im_ff;
            p1_re_ff <= rr_ff;
            p1_im_ff <= ri_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         xr_ff <= in_re;
         xi_ff <= in_im;
      end
      if (cmd.trig) begin
         sin_ff   <= sine_at(trig_addr);
         cos_ff   <= sine_at(trig_addr + TRIG_ADDR_BITS'(QLEN));
         gprod_ff <= gprod_in;
      end
      if (cmd.mul) begin
         xr_c_ff <= xr_ff * cos_ff;
         xi_s_ff <= xi_ff * sin_ff;
         xi_c_ff <= xi_ff * cos_ff;
         xr_s_ff <= xr_ff * sin_ff;
      end
      if (cmd.sum) begin
         rr_ff <= sat_sample(rot_re_sum >>> TRIG_FRAC);
         ri_ff <= sat_sample(rot_im_sum >>> TRIG_FRAC);
      end
      if (cmd.disc) begin
         out_re_ff   <= rr_ff;
         out_im_ff   <= ri_ff;
         freq_out_ff <= freq_ff;
      end
   end

   assign out_re        = out_re_ff;
   assign out_im        = out_im_ff;
   assign freq_estimate = freq_out_ff;

endmodule

### hdl/derivative_fll_derotator.sv
// Top level of the derivative FLL derotator: controller, datapath and checks.
// Depends on dfd_pkg, dfd_req_if, dfd_rsp_if, dfd_ctrl, dfd_dpath, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Derivative FLL derotator. Each input word carries one complex Q1.15 sample.
// The block rotates it by the conjugate of an NCO phasor, taken from a sine
// table addressed by the top bits of a phase fraction of one turn, and
// returns the saturated rotated sample with the frequency estimate after this
// sample's loop update. A cross-product discriminator over the current and
// two previous rotated samples produces an error that is applied one sample
// later: it is multiplied by the signed loop_gain, shifted right
// arithmetically by gain_shift and added to the wrapping 32-bit frequency,
// which then advances the phase. A word is accepted when idle or in the
// cycle the previous result is loaded, and passes through the trig lookup,
// multiply, sum and discriminator steps. No new word is taken before the
// previous one is through, since the phase updated from one sample must be
// in place before the sine lookup of the next. The result sits in an output
// register, so a waiting result does not hold back the next word until its
// own result is due. Registers (index 0 loop_gain, index 1 gain_shift)
// reset to zero and 32; the user is to write them through the csr port only
// while the block is idle, and the block itself does not enforce this.
module derivative_fll_derotator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [dfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dfd_pkg::CSR_DATA_W-1:0] csr_wdata,
   dfd_req_if.sink                        req_ch,
   dfd_rsp_if.source                      rsp_ch
);
   import dfd_pkg::*;

   dfd_cmd_type cmd;

   // Sequencing of the trig lookup, multiply, sum and discriminator steps.
   dfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // All arithmetic and loop state.
   dfd_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .in_re         (req_ch.in_re),
      .in_im         (req_ch.in_im),
      .out_re        (rsp_ch.out_re),
      .out_im        (rsp_ch.out_im),
      .freq_estimate (rsp_ch.freq_estimate)
   );

   // The four work steps never overlap.
   `ASSERT_ALWAYS(a_one_step, clock, reset, $onehot0({cmd.trig, cmd.mul, cmd.sum, cmd.disc}))

   // An accepted word starts its trig lookup in the next cycle.
   `ASSERT_NEXT(a_load_then_trig, clock, reset, cmd.load, cmd.trig)

   // A result is only loaded when the output register can take it.
   `ASSERT_IMPLIES(a_disc_free, clock, reset, cmd.disc, !rsp_ch.valid || rsp_ch.ready)

   // No result is offered in the cycle after reset.
   `ASSERT_IMPLIES(a_reset_empty, clock, 1'b0, $past(reset), !rsp_ch.valid)

endmodule

### tb/derivative_fll_derotator_test.sv
// Self-checking testbench of the derivative FLL derotator: a scoreboard class that
// predicts every result word, a sender and a receiver with random idling.
// Depends on dfd_pkg, dfd_req_if, dfd_rsp_if and derivative_fll_derotator.
`timescale 1ns / 1ps

module derivative_fll_derotator_test;
   import dfd_pkg::*;

   // A watchdog ends the run when no word moves on either channel for this many
   // cycles. The long receiver hold-off below stays well under it.
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int HOLD_CYCLES     = 400;
   localparam int HOLD_AT_RESULT  = 350;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_SAMPLES   = 100;
   localparam int SETTLE_CYCLES   = 8;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
      logic signed [FREQ_BITS-1:0]   freq;
   } fll_word_type;

   // The scoreboard keeps its own copy of the loop: NCO phase, frequency word,
   // the delayed discriminator error and the last two derotated samples. Each
   // accepted input word is run through it at once and the expected result word
   // is queued; result words are compared against the head of that queue.
   class fll_scoreboard_type;
      longint           quarter_tab [QLEN+1];
      logic [PHASE_BITS-1:0] phase_acc;
      logic [FREQ_BITS-1:0]  freq_word;
      longint           held_error;
      longint           rot_re_hist [2];
      longint           rot_im_hist [2];
      longint           gain_k;
      int unsigned      shift_n;
      fll_word_type     expected_q [$];
      int               errors;
      int               checked;

      function new();
         build_quarter_wave();
         phase_acc   = '0;
         freq_word   = '0;
         held_error  = 0;
         rot_re_hist = '{0, 0};
         rot_im_hist = '{0, 0};
         gain_k      = 0;
         shift_n     = 32;
         errors      = 0;
         checked     = 0;
      endfunction

      // Quarter-wave sine, amplitude 32767, from a Q30 Taylor series evaluated
      // with Horner's scheme; products back to Q30 are truncated, but the square is rounded.
      function void build_quarter_wave();
         longint divs [5] = '{110, 72, 42, 20, 6};
         longint x, x2, t, s, v;
         for (int j = 0; j <= QLEN; j++) begin
            x  = (HALF_PI_Q30 * longint'(j) + longint'(QLEN / 2)) / longint'(QLEN);
            x2 = (x * x + (64'sd1 <<< 29)) >>> 30;
            t  = Q30_ONE;
            for (int i = 0; i < 5; i++) begin
               t = Q30_ONE - ((x2 * t) >>> 30) / divs[i];
            end
            s = (x * t) >>> 30;
            v = (s * longint'(TRIG_ONE) + (64'sd1 <<< 29)) >>> 30;
            if (v > TRIG_ONE) begin
               v = TRIG_ONE;
            end
            if (v < 0) begin
               v = 0;
            end
            quarter_tab[j] = v;
         end
      endfunction

      function longint sine_lookup(input logic [TRIG_ADDR_BITS-1:0] k);
         int     quad;
         int     j;
         longint v;
         quad = int'(k >> (TRIG_ADDR_BITS - 2));
         j    = int'(k) & (QLEN - 1);
         if ((quad & 1) != 0) begin
            v = quarter_tab[QLEN - j];
         end else begin
            v = quarter_tab[j];
         end
         if ((quad & 2) != 0) begin
            v = -v;
         end
         return v;
      endfunction

      function longint clip_sample(input longint v);
         longint hi;
         longint lo;
         hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
         lo = -(64'sd1 <<< (SAMPLE_BITS - 1));
         if (v > hi) begin
            return hi;
         end
         if (v < lo) begin
            return lo;
         end
         return v;
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_LOOP_GAIN) begin
            gain_k = longint'($signed(value[GAIN_BITS-1:0]));
         end else if (idx == CSR_GAIN_SHIFT) begin
            shift_n = int'(value[SHIFT_BITS-1:0]);
         end
      endfunction

      function void note_sample(input logic signed [SAMPLE_BITS-1:0] in_re,
                                input logic signed [SAMPLE_BITS-1:0] in_im);
         longint xr, xi, c, s, rr, ri, disc, delta;
         logic [TRIG_ADDR_BITS-1:0] addr;
         fll_word_type w;
         xr   = in_re;
         xi   = in_im;
         addr = phase_acc[PHASE_BITS-1 -: TRIG_ADDR_BITS];
         s    = sine_lookup(addr);
         c    = sine_lookup(addr + TRIG_ADDR_BITS'(QLEN));
         // Rotate by the conjugate phasor, round half up, then saturate.
         rr   = clip_sample((xr * c + xi * s + 64'sd16384) >>> 15);
         ri   = clip_sample((xi * c - xr * s + 64'sd16384) >>> 15);
         // Cross product against the two previous derotated samples.
         disc = rot_re_hist[1] * (ri - rot_im_hist[0])
              - rot_im_hist[1] * (rr - rot_re_hist[0]);
         // The loop applies the error of the previous sample first.
         delta     = (gain_k * held_error) >>> shift_n;
         freq_word = freq_word + delta[FREQ_BITS-1:0];
         phase_acc = phase_acc + freq_word;
         held_error = disc;
         rot_re_hist[0] = rot_re_hist[1];
         rot_im_hist[0] = rot_im_hist[1];
         rot_re_hist[1] = rr;
         rot_im_hist[1] = ri;
         w.re   = rr[SAMPLE_BITS-1:0];
         w.im   = ri[SAMPLE_BITS-1:0];
         w.freq = freq_word;
         expected_q.push_back(w);
      endfunction

      function void report(input string field, input longint want, input longint got);
         errors++;
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      endfunction

      function void check_word(input fll_word_type got);
         fll_word_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $error("result word with no sample outstanding: re %0d im %0d freq %0d",
                   got.re, got.im, got.freq);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.re !== want.re) begin
            report("out_re", want.re, got.re);
         end
         if (got.im !== want.im) begin
            report("out_im", want.im, got.im);
         end
         if (got.freq !== want.freq) begin
            report("freq_estimate", want.freq, got.freq);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dfd_req_if req_bus ();
   dfd_rsp_if rsp_bus ();

   derivative_fll_derotator dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus)
   );

   fll_scoreboard_type sb;

   // Sender burst state and the tone generator used for most random words.
   int                        burst_left = 0;
   int                        run_left   = 0;
   bit                        run_tone;
   logic [TRIG_ADDR_BITS-1:0] tone_angle = '0;
   logic [TRIG_ADDR_BITS-1:0] tone_step;
   longint                    tone_amp;
   int                        settings_count = 1;
   bit                        hold_done = 1'b0;

   always #4 clock = ~clock;

   // Offers one word and waits until the block takes it. The sender works in
   // bursts: after a burst it lowers valid for a random gap, and a gap of zero
   // simply keeps valid high into the next word.
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] re,
                              input logic signed [SAMPLE_BITS-1:0] im);
      int gap;
      req_bus.valid <= 1'b1;
      req_bus.in_re <= re;
      req_bus.in_im <= im;
      do begin
         @(posedge clock);
      end while (req_bus.ready !== 1'b1);
      sb.note_sample(re, im);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = $urandom_range(0, 12);
         burst_left = $urandom_range(0, 40);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Lowers valid and waits until every expected word has come back, plus a
   // few cycles so that the block is surely idle before a register write.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.expected_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers in back-to-back cycles; the write enable is
   // lowered only once, after the second write.
   task automatic configure(input logic [GAIN_BITS-1:0] gain_val,
                            input logic [SHIFT_BITS-1:0] shift_val);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_LOOP_GAIN;
      csr_wdata <= CSR_DATA_W'(gain_val);
      @(posedge clock);
      sb.write_reg(CSR_LOOP_GAIN, CSR_DATA_W'(gain_val));
      csr_index <= CSR_GAIN_SHIFT;
      csr_wdata <= CSR_DATA_W'(shift_val);
      @(posedge clock);
      sb.write_reg(CSR_GAIN_SHIFT, CSR_DATA_W'(shift_val));
      csr_wr_en <= 1'b0;
      @(posedge clock);
      settings_count++;
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] pick_extreme();
      case ($urandom_range(0, 4))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return 16'sh0001;
         default: return 16'shFFFF;
      endcase
   endfunction

   // Random words come in runs. Most runs are a rotating tone with a small
   // amount of noise, which the loop can track; the rest are raw noise with
   // full-scale values mixed in.
   task automatic next_random(output logic signed [SAMPLE_BITS-1:0] re,
                              output logic signed [SAMPLE_BITS-1:0] im);
      longint c;
      longint s;
      if (run_left == 0) begin
         run_tone  = ($urandom_range(0, 9) < 7);
         run_left  = $urandom_range(5, 60);
         tone_step = TRIG_ADDR_BITS'($urandom_range(0, 63) - 32);
         tone_amp  = $urandom_range(0, 32000);
      end
      run_left--;
      if (run_tone) begin
         c = sb.sine_lookup(tone_angle + TRIG_ADDR_BITS'(QLEN));
         s = sb.sine_lookup(tone_angle);
         re = SAMPLE_BITS'(((tone_amp * c) >>> 15) + $urandom_range(0, 15) - 8);
         im = SAMPLE_BITS'(((tone_amp * s) >>> 15) + $urandom_range(0, 15) - 8);
         tone_angle = tone_angle + tone_step;
      end else begin
         re = ($urandom_range(0, 3) == 0) ? pick_extreme() : SAMPLE_BITS'($urandom());
         im = ($urandom_range(0, 3) == 0) ? pick_extreme() : SAMPLE_BITS'($urandom());
      end
   endtask

   // Receiver: checks every word it takes and then picks ready for the next
   // cycle. Its stall pattern is redrawn regularly from always ready, coin
   // flips, ready a quarter of the time and mostly ready. Once, after a few
   // hundred results, it holds ready low for a long stretch while the sender
   // keeps offering words, so the output register fills and the input stalls.
   initial begin : receiver
      int           cyc;
      int           stall_mode;
      int           hold_left;
      fll_word_type got;
      cyc        = 0;
      stall_mode = 0;
      hold_left  = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.re   = rsp_bus.out_re;
            got.im   = rsp_bus.out_im;
            got.freq = rsp_bus.freq_estimate;
            sb.check_word(got);
         end
         if (!hold_done && sb.checked >= HOLD_AT_RESULT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (cyc % 50 == 0) begin
            stall_mode = $urandom_range(0, 3);
         end
         cyc++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
               2:       rsp_bus.ready <= (cyc % 4 == 0);
               default: rsp_bus.ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // Watchdog: counts cycles in which no word moves on either channel.
   initial begin : watchdog
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if (reset === 1'b1 ||
             (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
            idle = 0;
         end else begin
            idle++;
         end
         if (idle >= WATCHDOG_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic signed [SAMPLE_BITS-1:0] corner_re [10];
      logic signed [SAMPLE_BITS-1:0] corner_im [10];
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
      logic [GAIN_BITS-1:0]          gain_val;
      logic [SHIFT_BITS-1:0]         shift_val;

      corner_re = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000,
                    16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh5555};
      corner_im = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh8000,
                    16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'shAAAA};

      sb = new();
      reset         <= 1'b1;
      csr_wr_en     <= 1'b0;
      csr_index     <= CSR_LOOP_GAIN;
      csr_wdata     <= '0;
      req_bus.valid <= 1'b0;
      req_bus.in_re <= '0;
      req_bus.in_im <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: zero gain, so the NCO stays at phase zero and the
      // rotation is the identity apart from rounding of values of large magnitude.
      for (int i = 0; i < 10; i++) begin
         send_sample(corner_re[i], corner_im[i]);
      end
      drain();

      // Largest positive gain with no shift: full-scale errors drive the
      // frequency word past its range so it wraps, and the phase wraps too.
      configure(16'h7FFF, 6'd0);
      for (int i = 0; i < 10; i++) begin
         send_sample(corner_re[9 - i], corner_im[9 - i]);
      end
      drain();

      // Most negative gain with the largest shift: each update is 0 or -1.
      configure(16'h8000, 6'd63);
      for (int i = 0; i < 5; i++) begin
         send_sample(corner_re[i + 5], corner_im[i + 5]);
      end
      drain();

      // Random phases, each with a fresh pair of register values. The shift
      // cycles through zero, the maximum, a range where the loop behaves like
      // a real tracking loop, and anything at all.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       gain_val = 16'h7FFF;
            1:       gain_val = 16'h8000;
            default: gain_val = GAIN_BITS'($urandom());
         endcase
         case (p % 4)
            0:       shift_val = 6'd0;
            1:       shift_val = 6'd63;
            2:       shift_val = SHIFT_BITS'($urandom_range(24, 40));
            default: shift_val = SHIFT_BITS'($urandom_range(0, 63));
         endcase
         configure(gain_val, shift_val);
         for (int i = 0; i < PHASE_SAMPLES; i++) begin
            next_random(re, im);
            send_sample(re, im);
         end
         drain();
      end

      repeat (20) @(posedge clock);
      $display("Checked %0d result words over %0d register settings, gain and shift",
               sb.checked, settings_count);
      $display("extremes included, with tone and noise input and a long output stall.");
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/dfd_pkg.sv
hdl/dfd_req_if.sv
hdl/dfd_rsp_if.sv
hdl/dfd_ctrl.sv
hdl/dfd_dpath.sv
hdl/derivative_fll_derotator.sv
tb/derivative_fll_derotator_test.sv
